### hw/rtl/gsp_pkg.sv
package gsp_pkg;

  localparam int POOL_SLOTS_DEF = 256;
  localparam int IDX_REACH      = 256;
  localparam int GRP_SLOTS      = 16;
  localparam int GRP_BITS       = 4;
  localparam int GEN_W          = 8;
  localparam int SLOT_W         = 8;
  localparam int CAP_W          = 9;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEEK,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } find_res_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic              clear_all;
    logic [SLOT_W-1:0] slot;
  } live_upd_t;

endpackage

### hw/rtl/gsp_req_if.sv
interface gsp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] slot_index;
  logic [7:0] handle_generation;

  modport source (output valid, output operation, output slot_index,
                  output handle_generation, input ready);
  modport sink (input valid, input operation, input slot_index,
                input handle_generation, output ready);
endinterface

### hw/rtl/gsp_rsp_if.sv
interface gsp_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_index;
  logic [7:0] out_generation;
  logic [8:0] live_count;

  modport source (output valid, output status, output out_index,
                  output out_generation, output live_count, input ready);
  modport sink (input valid, input status, input out_index,
                input out_generation, input live_count, output ready);
endinterface

### hw/rtl/gsp_cfg_if.sv
interface gsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] pool_capacity;

  modport source (output valid, output pool_capacity, input ready);
  modport sink (input valid, input pool_capacity, output ready);
endinterface

### hw/rtl/gsp_gen_ram.sv
module gsp_gen_ram
  import gsp_pkg::*;
#(
  parameter int DEPTH = POOL_SLOTS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [GEN_W-1:0] rd_gen,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [GEN_W-1:0] wr_gen
);

  logic [GEN_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written_r;
  logic [GEN_W-1:0] rd_data_r;
  logic             rd_written_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_gen;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // written flags stand in for the all-zero reset of the generations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_gen = rd_written_r ? rd_data_r : '0;

endmodule

### hw/rtl/gsp_free_finder.sv
module gsp_free_finder
  import gsp_pkg::*;
#(
  parameter int DEPTH = POOL_SLOTS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CAP_W-1:0] eff_cap,
  input  live_upd_t        upd,
  input  logic [IDX_W-1:0] q_idx,
  output logic             q_live,
  output find_res_t        res
);

  localparam int NGRP = (DEPTH + GRP_SLOTS - 1) / GRP_SLOTS;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;

  logic [DEPTH-1:0]          live_r;
  logic [NGRP*GRP_SLOTS-1:0] pad_live;
  logic [NGRP-1:0]           grp_open;
  logic [GRP_SLOTS-1:0]      grp_bits;
  logic [GRP_SLOTS-1:0]      bit_free;
  logic [GW-1:0]             sel_g;
  logic [GRP_BITS-1:0]       sel_b;
  logic                      any_g;
  logic                      any_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (upd.clear_all) begin
      live_r <= '0;
    end else if (upd.set) begin
      live_r[upd.slot[IDX_W-1:0]] <= 1'b1;
    end else if (upd.clr) begin
      live_r[upd.slot[IDX_W-1:0]] <= 1'b0;
    end
  end

  assign q_live = live_r[q_idx];

  // padding slots read as live so they are never picked
  always_comb begin
    pad_live              = '1;
    pad_live[DEPTH-1:0]   = live_r;
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_open[g] = !(&pad_live[g*GRP_SLOTS +: GRP_SLOTS]) &&
                    (CAP_W'(g * GRP_SLOTS) < eff_cap);
    end
  end

  always_comb begin
    sel_g = '0;
    any_g = 1'b0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_open[g]) begin
        sel_g = GW'(g);
        any_g = 1'b1;
      end
    end
  end

  assign grp_bits = pad_live[{sel_g, {GRP_BITS{1'b0}}} +: GRP_SLOTS];

  always_comb begin
    for (int b = 0; b < GRP_SLOTS; b++) begin
      bit_free[b] = !grp_bits[b] &&
                    (CAP_W'({sel_g, GRP_BITS'(b)}) < eff_cap);
    end
  end

  always_comb begin
    sel_b = '0;
    any_b = 1'b0;
    for (int b = GRP_SLOTS - 1; b >= 0; b--) begin
      if (bit_free[b]) begin
        sel_b = GRP_BITS'(b);
        any_b = 1'b1;
      end
    end
  end

  assign res.found = any_g && any_b;
  assign res.slot  = SLOT_W'({sel_g, sel_b});

endmodule

### hw/rtl/generational_slot_pool.sv
// Generational slot pool. Allocate takes the lowest free slot below the
// configured capacity, advances its 8-bit generation (0 is skipped) and returns
// index and generation, or pool full. Release and check accept a handle only
// if its generation is nonzero, its index is below the capacity, the slot is
// live and the generations match; anything else reports a stale handle and
// changes nothing. Clear all frees every slot and keeps the generations.
// Each transaction runs through a lookup state, which searches the live bitmap
// and reads the generation RAM, and a write-back state, which writes back and
// loads the response register. A new request is taken in the write-back cycle
// of the one before it while responses are drained; a response left waiting
// holds the next request in its write-back cycle. Capacity may be written only
// while idle. No clearing pass is needed after reset.
module generational_slot_pool
  import gsp_pkg::*;
#(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gsp_req_if.sink   in_req,
  gsp_rsp_if.source out_rsp,
  gsp_cfg_if.sink   cfg_wr
);

  localparam int SLOT_DEPTH = (POOL_SLOTS < IDX_REACH) ? POOL_SLOTS : IDX_REACH;
  localparam int IDX_W      = $clog2(SLOT_DEPTH);

  state_t             state_r, state_nxt;
  op_t                op_r;
  logic [SLOT_W-1:0]  idx_r;
  logic [GEN_W-1:0]   hgen_r;
  find_res_t          find_r;
  find_res_t          find_res;
  logic [CAP_W-1:0]   cap_r;
  logic [CAP_W-1:0]   live_total_r, live_total_nxt;

  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic [SLOT_W-1:0]  oidx_r, oidx_nxt;
  logic [GEN_W-1:0]   ogen_r, ogen_nxt;
  logic [CAP_W-1:0]   ocount_r;

  logic               accept;
  logic               commit;
  logic               seek;
  logic [GEN_W-1:0]   rd_gen;
  logic [GEN_W-1:0]   new_gen;
  logic               q_live;
  logic               in_range;
  logic               handle_ok;
  logic               alloc_ok;
  logic [IDX_W-1:0]   rd_addr;
  live_upd_t          upd;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(SLOT_DEPTH);
    end else if (cfg_wr.valid) begin
      cap_r <= (cfg_wr.pool_capacity > CAP_W'(SLOT_DEPTH)) ?
               CAP_W'(SLOT_DEPTH) : cfg_wr.pool_capacity;
    end
  end

  gsp_free_finder #(
    .DEPTH (SLOT_DEPTH),
    .IDX_W (IDX_W)
  ) u_finder (
    .clk     (clk),
    .rst_n   (rst_n),
    .eff_cap (cap_r),
    .upd     (upd),
    .q_idx   (idx_r[IDX_W-1:0]),
    .q_live  (q_live),
    .res     (find_res)
  );

  assign rd_addr = (op_r == OP_ALLOC) ? find_res.slot[IDX_W-1:0] : idx_r[IDX_W-1:0];

  gsp_gen_ram #(
    .DEPTH (SLOT_DEPTH),
    .IDX_W (IDX_W)
  ) u_gen_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (seek),
    .rd_addr (rd_addr),
    .rd_gen  (rd_gen),
    .wr_en   (upd.set),
    .wr_addr (find_r.slot[IDX_W-1:0]),
    .wr_gen  (new_gen)
  );

  always_comb begin
    state_nxt    = state_r;
    seek         = 1'b0;
    commit       = 1'b0;
    in_req.ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          state_nxt = S_SEEK;
        end
      end
      S_SEEK: begin
        seek      = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || out_rsp.ready) begin
          commit       = 1'b1;
          in_req.ready = 1'b1;
          state_nxt    = in_req.valid ? S_SEEK : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign accept = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_req.operation);
      idx_r  <= in_req.slot_index;
      hgen_r <= in_req.handle_generation;
    end
    if (seek) begin
      find_r <= find_res;
    end
  end

  assign in_range  = {1'b0, idx_r} < cap_r;
  assign handle_ok = (hgen_r != '0) && in_range && q_live && (rd_gen == hgen_r);
  assign alloc_ok  = find_r.found && (live_total_r < cap_r);
  assign new_gen   = (rd_gen == '1) ? GEN_W'(1) : rd_gen + GEN_W'(1);

  always_comb begin
    upd            = '0;
    upd.slot       = (op_r == OP_ALLOC) ? find_r.slot : idx_r;
    live_total_nxt = live_total_r;
    status_nxt     = ST_OK;
    oidx_nxt       = '0;
    ogen_nxt       = '0;
    if (op_r == OP_ALLOC) begin
      if (alloc_ok) begin
        upd.set        = commit;
        live_total_nxt = live_total_r + CAP_W'(1);
        oidx_nxt       = find_r.slot;
        ogen_nxt       = new_gen;
      end else begin
        status_nxt = ST_FULL;
      end
    end else if (op_r == OP_RELEASE || op_r == OP_CHECK) begin
      if (handle_ok) begin
        oidx_nxt = idx_r;
        ogen_nxt = rd_gen;
        if (op_r == OP_RELEASE) begin
          upd.clr = commit;
          if (live_total_r != '0) begin
            live_total_nxt = live_total_r - CAP_W'(1);
          end
        end
      end else begin
        status_nxt = ST_BAD;
      end
    end else begin
      upd.clear_all  = commit;
      live_total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (commit) begin
        live_total_r <= live_total_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_r <= status_nxt;
      oidx_r   <= oidx_nxt;
      ogen_r   <= ogen_nxt;
      ocount_r <= live_total_nxt;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = status_r;
  assign out_rsp.out_index      = oidx_r;
  assign out_rsp.out_generation = ogen_r;
  assign out_rsp.live_count     = ocount_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_total_r <= CAP_W'(SLOT_DEPTH))
    else $error("live count beyond pool depth");

  a_rsp_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COMMIT))
    else $error("response raised outside write-back");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (oidx_r == '0 && ogen_r == '0))
    else $error("pool full response carries a handle");

  a_alloc_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    upd.set |-> (new_gen != '0 && !upd.clr && !upd.clear_all))
    else $error("allocation with zero generation or conflicting update");

  a_seek_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEEK) |=> (state_r == S_COMMIT))
    else $error("lookup not followed by write-back");
`endif

endmodule

### verif/tb_top.sv
module tb_top
  import gsp_pkg::*;
();

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 90;

  typedef struct {
    status_t  status;
    bit [7:0] slot;
    bit [7:0] generation;
    bit [8:0] live_count;
  } pool_reply_t;

  class slot_pool_scoreboard;
    bit          alive [IDX_REACH];
    bit [7:0]    gen_of [IDX_REACH];
    int unsigned live_total;
    bit [8:0]    capacity;
    pool_reply_t reply_q [$];
    int unsigned errors;

    function new();
      foreach (alive[i]) begin
        alive[i]  = 1'b0;
        gen_of[i] = 8'd0;
      end
      live_total = 0;
      capacity   = 9'd256;
      errors     = 0;
    endfunction

    function int unsigned usable_slots();
      int unsigned cap;
      cap = capacity;
      if (cap > POOL_SLOTS_DEF) cap = POOL_SLOTS_DEF;
      if (cap > IDX_REACH) cap = IDX_REACH;
      return cap;
    endfunction

    function bit handle_ok(bit [7:0] idx, bit [7:0] g);
      if (g == 8'd0) return 1'b0;
      if (idx >= usable_slots()) return 1'b0;
      if (!alive[idx]) return 1'b0;
      return gen_of[idx] == g;
    endfunction

    function int pending();
      return reply_q.size();
    endfunction

    // Predicts the reply to an accepted request and updates the slot state.
    function void note_request(op_t op, bit [7:0] idx, bit [7:0] g);
      pool_reply_t r;
      int unsigned cap;
      int          found;
      r.status     = ST_OK;
      r.slot       = 8'd0;
      r.generation = 8'd0;
      cap          = usable_slots();
      found        = -1;
      case (op)
        OP_ALLOC: begin
          if (live_total < cap) begin
            for (int i = 0; i < int'(cap) && found < 0; i++) begin
              if (!alive[i]) found = i;
            end
          end
          if (found >= 0) begin
            gen_of[found] = gen_of[found] + 8'd1;
            if (gen_of[found] == 8'd0) gen_of[found] = 8'd1;
            alive[found] = 1'b1;
            live_total++;
            r.slot       = found[7:0];
            r.generation = gen_of[found];
          end else begin
            r.status = ST_FULL;
          end
        end
        OP_RELEASE, OP_CHECK: begin
          if (handle_ok(idx, g)) begin
            r.slot       = idx;
            r.generation = gen_of[idx];
            if (op == OP_RELEASE) begin
              alive[idx] = 1'b0;
              if (live_total > 0) live_total--;
            end
          end else begin
            r.status = ST_BAD;
          end
        end
        default: begin
          foreach (alive[i]) alive[i] = 1'b0;
          live_total = 0;
        end
      endcase
      r.live_count = live_total[8:0];
      reply_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [7:0] slot, logic [7:0] g,
                               logic [8:0] cnt);
      pool_reply_t e;
      if (reply_q.size() == 0) begin
        $error("unexpected transaction: status %0d slot %0d generation %0d live %0d",
               st, slot, g, cnt);
        errors++;
        return;
      end
      e = reply_q.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (slot !== e.slot) begin
        $error("out_index: expected %0d, actual %0d", e.slot, slot);
        errors++;
      end
      if (g !== e.generation) begin
        $error("out_generation: expected %0d, actual %0d", e.generation, g);
        errors++;
      end
      if (cnt !== e.live_count) begin
        $error("live_count: expected %0d, actual %0d", e.live_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  gsp_req_if req_if ();
  gsp_rsp_if rsp_if ();
  gsp_cfg_if cfg_if ();

  generational_slot_pool dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if),
    .cfg_wr (cfg_if)
  );

  slot_pool_scoreboard pool_sb = new();

  int       burst_left  = 0;
  bit       eager       = 1'b0;
  bit       hold_rsp    = 1'b0;
  int       stall_left  = 0;
  int       pat_age     = 0;
  bit [7:0] ready_pat   = 8'hFF;
  int       quiet_cycles = 0;

  // Receiver pacing: rotating stall pattern, plus a long hold-off on request.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (hold_rsp) begin
      hold_rsp   = 1'b0;
      stall_left = HOLD_CYCLES - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age   = $urandom_range(20, 80);
        ready_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        if (ready_pat == 8'h00) ready_pat = 8'h81;
      end
      pat_age--;
      rsp_if.ready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[7:1]};
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready)
      pool_sb.check_result(rsp_if.status, rsp_if.out_index, rsp_if.out_generation,
                           rsp_if.live_count);
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("generational_slot_pool regression: fail");
      $finish;
    end
  end

  task automatic send_item(op_t op, bit [7:0] idx, bit [7:0] g);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = eager ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req_if.valid             <= 1'b1;
    req_if.operation         <= op;
    req_if.slot_index        <= idx;
    req_if.handle_generation <= g;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pool_sb.note_request(op, idx, g);
    burst_left--;
  endtask

  // Stop offering and wait for every outstanding reply.
  task automatic settle();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pool_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(bit [8:0] cap);
    cfg_if.valid         <= 1'b1;
    cfg_if.pool_capacity <= cap;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    pool_sb.capacity = cap;
    @(posedge clk);
  endtask

  function automatic int pick_live();
    int found [$];
    for (int i = 0; i < IDX_REACH; i++) begin
      if (pool_sb.alive[i]) found.push_back(i);
    end
    if (found.size() == 0) return -1;
    return found[$urandom_range(0, found.size() - 1)];
  endfunction

  function automatic int pick_retired();
    int found [$];
    for (int i = 0; i < IDX_REACH; i++) begin
      if (!pool_sb.alive[i] && pool_sb.gen_of[i] != 8'd0) found.push_back(i);
    end
    if (found.size() == 0) return -1;
    return found[$urandom_range(0, found.size() - 1)];
  endfunction

  // Mostly live handles, with stale, zero-generation and random handles mixed in.
  task automatic random_traffic(int count, bit clear_ok);
    int       roll;
    int       s;
    op_t      op;
    bit [7:0] idx;
    bit [7:0] g;
    repeat (count) begin
      roll = $urandom_range(0, clear_ok ? 99 : 96);
      idx  = 8'($urandom);
      g    = 8'($urandom);
      if (roll < 38) begin
        op = OP_ALLOC;
      end else if (roll < 75) begin
        op = (roll < 60) ? OP_RELEASE : OP_CHECK;
        s  = pick_live();
        if (s >= 0) begin
          idx = s[7:0];
          g   = pool_sb.gen_of[s];
        end
      end else if (roll < 97) begin
        op = $urandom_range(0, 1) ? OP_RELEASE : OP_CHECK;
        case ($urandom_range(0, 3))
          0: begin
            s = pick_live();
            if (s >= 0) begin
              idx = s[7:0];
              g   = pool_sb.gen_of[s] + 8'($urandom_range(1, 255));
            end
          end
          1: begin
            s = pick_live();
            if (s >= 0) idx = s[7:0];
            g = 8'd0;
          end
          2: begin
            s = pick_retired();
            if (s >= 0) begin
              idx = s[7:0];
              g   = pool_sb.gen_of[s];
            end
          end
          default: ;
        endcase
      end else begin
        op = OP_CLEAR;
      end
      send_item(op, idx, g);
    end
  endtask

  initial begin
    req_if.valid             = 1'b0;
    req_if.operation         = OP_ALLOC;
    req_if.slot_index        = 8'd0;
    req_if.handle_generation = 8'd0;
    rsp_if.ready             = 1'b0;
    cfg_if.valid             = 1'b0;
    cfg_if.pool_capacity     = 9'd256;
    rst_n                    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, capacity at its reset value
    send_item(OP_CHECK, 8'd0, 8'd0);
    send_item(OP_ALLOC, 8'd0, 8'd0);
    send_item(OP_ALLOC, 8'd0, 8'd0);
    send_item(OP_ALLOC, 8'd255, 8'd255);
    send_item(OP_CHECK, 8'd1, 8'd1);
    send_item(OP_CHECK, 8'd1, 8'd0);
    send_item(OP_CHECK, 8'd1, 8'd2);
    send_item(OP_RELEASE, 8'd0, 8'd1);
    send_item(OP_RELEASE, 8'd0, 8'd1);
    send_item(OP_ALLOC, 8'd0, 8'd0);
    send_item(OP_CHECK, 8'd0, 8'd1);
    send_item(OP_CHECK, 8'd255, 8'd255);
    send_item(OP_RELEASE, 8'd200, 8'd1);
    send_item(OP_CLEAR, 8'd0, 8'd0);
    send_item(OP_CHECK, 8'd0, 8'd2);
    send_item(OP_ALLOC, 8'd0, 8'd0);
    send_item(OP_RELEASE, 8'd0, pool_sb.gen_of[0]);
    settle();

    // small pool: fill, overflow, out-of-range index, then a long response hold-off
    write_capacity(9'd3);
    repeat (4) send_item(OP_ALLOC, 8'($urandom), 8'($urandom));
    send_item(OP_CHECK, 8'd3, 8'd1);
    send_item(OP_CHECK, 8'd2, pool_sb.gen_of[2]);
    hold_rsp = 1'b1;
    random_traffic(120, 1'b1);
    settle();

    // single slot: churn it until the generation wraps past zero
    write_capacity(9'd1);
    send_item(OP_CLEAR, 8'd0, 8'd0);
    repeat (256) begin
      send_item(OP_ALLOC, 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 7) == 0) send_item(OP_ALLOC, 8'd0, 8'd0);
      if ($urandom_range(0, 4) == 0) send_item(OP_CHECK, 8'd0, pool_sb.gen_of[0]);
      send_item(OP_RELEASE, 8'd0, pool_sb.gen_of[0]);
    end
    settle();

    write_capacity(9'd256);
    eager = 1'b1;
    random_traffic(120, 1'b0);
    eager = 1'b0;
    hold_rsp = 1'b1;
    random_traffic(70, 1'b0);
    settle();

    // capacity lowered under live slots
    write_capacity(9'd8);
    random_traffic(100, 1'b1);
    settle();

    write_capacity(9'd0);
    random_traffic(30, 1'b1);
    settle();

    write_capacity(9'd511);
    random_traffic(50, 1'b1);
    settle();

    write_capacity(9'd300);
    random_traffic(40, 1'b1);
    settle();
    repeat (8) @(posedge clk);

    if (pool_sb.errors == 0 && pool_sb.pending() == 0) begin
      $display("generational_slot_pool regression: pass");
    end else begin
      $display("generational_slot_pool regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/gsp_pkg.sv
hw/rtl/gsp_req_if.sv
hw/rtl/gsp_rsp_if.sv
hw/rtl/gsp_cfg_if.sv
hw/rtl/gsp_gen_ram.sv
hw/rtl/gsp_free_finder.sv
hw/rtl/generational_slot_pool.sv
verif/tb_top.sv
